// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/mcdt_pkg.sv
// ----------------------------------------------------------------------------
// mcdt_pkg
// types and constants of the multi-channel delay timer
// ----------------------------------------------------------------------------
package mcdt_pkg;

   localparam int TIME_W      = 30;
   localparam int ELAPSED_W   = 16;
   localparam int CHAN_W      = 5;
   localparam int COUNT_W     = 6;
   localparam int OP_W        = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 6;
   localparam int MAX_RESULTS = 32;
   localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
   localparam logic [OP_W-1:0] OP_ACT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEACT  = 3'd3;
   localparam logic [OP_W-1:0] OP_PAUSE  = 3'd4;
   localparam logic [OP_W-1:0] OP_RESUME = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]      operation;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic [CHAN_W-1:0]    channel_index;
      logic [TIME_W-1:0]    delay_ms;
   } req_type;

   typedef struct packed {
      logic              fired;
      logic [CHAN_W-1:0] fired_channel;
      logic              running;
      logic              last;
   } rsp_type;

endpackage

// File: rtl/multi_channel_delay_timer_core.sv
// ----------------------------------------------------------------------------
// multi_channel_delay_timer_core
// bank of one-shot delay channels, remaining times kept in block memory
// ----------------------------------------------------------------------------
// sequence: every beat is decoded and ends in a flush that waits for output
//    space; activate copies, a chain tick steps and a parallel tick scans between
// throughput: one item at a time; activate, or a parallel tick while no
//    firing waits for output space, walks one channel per cycle through the
//    single read port of each memory
// reset: synchronous, clears control, armed and written flags; no clearing pass
`include "assert_macros.svh"

module multi_channel_delay_timer_core
   import mcdt_pkg::*;
#(
   parameter int NUM_CHANNELS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // address width and a counter width that can hold the channel count itself
   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
   localparam logic [COUNT_W:0] NUM_EXT = (COUNT_W + 1)'(NUM_CHANNELS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ACT,
      S_CHAIN,
      S_SCAN,
      S_FLUSH
   } state_type;

   // control registers
   state_type              state_ff, state_in;
   logic                   chain_mode_ff, chain_mode_in;
   logic [COUNT_W-1:0]     chan_count_ff, chan_count_in;
   logic [NUM_CHANNELS-1:0] armed_ff, armed_in;
   logic [NUM_CHANNELS-1:0] rem_written_ff, rem_written_in;
   logic [COUNT_W-1:0]     chain_pos_ff, chain_pos_in;
   logic                   active_ff, active_in;
   logic                   paused_ff, paused_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   req_type                req_ff, req_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [CHAN_W-1:0]      pend_ch_ff, pend_ch_in;
   logic [CNT_W-1:0]       iss_ff, iss_in;
   logic                   e_valid_ff, e_valid_in;
   logic [IDX_W-1:0]       e_idx_ff, e_idx_in;
   logic [FIRE_W-1:0]      fire_cnt_ff, fire_cnt_in;

   // memories and their ports
   logic [TIME_W-1:0] rem_mem [NUM_CHANNELS];
   logic [TIME_W-1:0] dly_mem [NUM_CHANNELS];
   logic              rem_we, rem_re, dly_we, dly_re;
   logic [IDX_W-1:0]  rem_wa, rem_ra, dly_wa, dly_ra;
   logic [TIME_W-1:0] rem_wd, dly_wd;
   logic [TIME_W-1:0] rem_rd_ff, dly_rd_ff;
   logic              rd_written_ff;

   // helpers
   logic [CNT_W-1:0]        used_cnt;
   logic [COUNT_W:0]        count_ext;
   logic [NUM_CHANNELS-1:0] used_mask;
   logic                    any_armed;
   logic                    out_free;
   logic                    push;
   rsp_type                 push_data;
   logic [TIME_W-1:0]       cur_time, elapsed_ext, sub_time;
   logic                    due;
   logic                    scan_fire, scan_stall;
   logic [IDX_W-1:0]        iss_idx, pos_idx;

   // channel count clamped to the bank size
   assign count_ext = {1'b0, chan_count_ff};
   assign used_cnt  = (count_ext > NUM_EXT) ? CNT_W'(NUM_EXT) : CNT_W'(count_ext);

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         used_mask[i] = CNT_W'(i) < used_cnt;
      end
   end

   assign any_armed = |(armed_ff & used_mask);

   // output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // count-down arithmetic on the entry last read
   assign cur_time    = rd_written_ff ? rem_rd_ff : '0;
   assign elapsed_ext = TIME_W'(req_ff.elapsed_ms);
   assign due         = cur_time <= elapsed_ext;
   assign sub_time    = cur_time - elapsed_ext;

   assign iss_idx = iss_ff[IDX_W-1:0];
   assign pos_idx = IDX_W'(chain_pos_ff);

   // parallel scan: a firing that has to push the held beat out waits for space
   assign scan_fire  = e_valid_ff && armed_ff[e_idx_ff] &&
                       (fire_cnt_ff < FIRE_W'(MAX_RESULTS)) && due;
   assign scan_stall = scan_fire && pend_valid_ff && !out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in       = state_ff;
      chain_mode_in  = chain_mode_ff;
      chan_count_in  = chan_count_ff;
      armed_in       = armed_ff;
      rem_written_in = rem_written_ff;
      chain_pos_in   = chain_pos_ff;
      active_in      = active_ff;
      paused_in      = paused_ff;
      req_in         = req_ff;
      pend_valid_in  = pend_valid_ff;
      pend_ch_in     = pend_ch_ff;
      iss_in         = iss_ff;
      e_valid_in     = e_valid_ff;
      e_idx_in       = e_idx_ff;
      fire_cnt_in    = fire_cnt_ff;
      push           = 1'b0;
      push_data      = '0;
      rem_we         = 1'b0;
      rem_wa         = e_idx_ff;
      rem_wd         = '0;
      rem_re         = 1'b0;
      rem_ra         = iss_idx;
      dly_we         = 1'b0;
      dly_wa         = IDX_W'(req_ff.channel_index);
      dly_wd         = req_ff.delay_ms;
      dly_re         = 1'b0;
      dly_ra         = iss_idx;

      // register writes must only come while the bank is idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            CSR_CHAIN_MODE:    chain_mode_in = csr_wdata[0];
            CSR_CHANNEL_COUNT: chan_count_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            pend_valid_in = 1'b0;
            state_in      = S_FLUSH;
            unique case (req_ff.operation)
               OP_TICK: begin
                  if (active_ff && !paused_ff) begin
                     if (chain_mode_ff) begin
                        // position past the last channel stops the bank
                        if ((COUNT_W + 1)'(chain_pos_ff) >= (COUNT_W + 1)'(used_cnt)) begin
                           active_in = 1'b0;
                        end else begin
                           rem_re   = 1'b1;
                           rem_ra   = pos_idx;
                           state_in = S_CHAIN;
                        end
                     end else if (!any_armed) begin
                        active_in = 1'b0;
                     end else begin
                        // first read of the scan; used count is at least one here
                        rem_re      = 1'b1;
                        rem_ra      = '0;
                        iss_in      = CNT_W'(1);
                        e_valid_in  = 1'b1;
                        e_idx_in    = '0;
                        fire_cnt_in = '0;
                        state_in    = S_SCAN;
                     end
                  end
               end
               OP_LOAD: begin
                  if ((COUNT_W + 1)'(req_ff.channel_index) < NUM_EXT) begin
                     dly_we = 1'b1;
                  end
               end
               OP_ACT: begin
                  armed_in     = armed_ff | used_mask;
                  chain_pos_in = '0;
                  paused_in    = 1'b0;
                  active_in    = 1'b1;
                  iss_in       = '0;
                  e_valid_in   = 1'b0;
                  state_in     = S_ACT;
               end
               OP_DEACT:  active_in = 1'b0;
               OP_PAUSE:  paused_in = 1'b1;
               OP_RESUME: paused_in = 1'b0;
               default: ;
            endcase
         end

         // copy delays into remaining times, one channel a cycle
         S_ACT: begin
            if (e_valid_ff) begin
               rem_we                   = 1'b1;
               rem_wa                   = e_idx_ff;
               rem_wd                   = dly_rd_ff;
               rem_written_in[e_idx_ff] = 1'b1;
            end
            if (iss_ff < used_cnt) begin
               dly_re     = 1'b1;
               dly_ra     = iss_idx;
               e_idx_in   = iss_idx;
               e_valid_in = 1'b1;
               iss_in     = iss_ff + CNT_W'(1);
            end else begin
               e_valid_in = 1'b0;
               state_in   = S_FLUSH;
            end
         end

         // chain step: count the current channel whether armed or not
         S_CHAIN: begin
            rem_we                  = 1'b1;
            rem_wa                  = pos_idx;
            rem_written_in[pos_idx] = 1'b1;
            if (due) begin
               rem_wd            = '0;
               armed_in[pos_idx] = 1'b0;
               pend_valid_in     = 1'b1;
               pend_ch_in        = CHAN_W'(chain_pos_ff);
               chain_pos_in      = chain_pos_ff + COUNT_W'(1);
            end else begin
               rem_wd = sub_time;
            end
            state_in = S_FLUSH;
         end

         // parallel scan: evaluate the entry last read, read the next one;
         // a firing is held back one beat so that the final one can carry last
         S_SCAN: begin
            if (!scan_stall) begin
               if (e_valid_ff && armed_ff[e_idx_ff]) begin
                  rem_we                   = 1'b1;
                  rem_wa                   = e_idx_ff;
                  rem_written_in[e_idx_ff] = 1'b1;
                  if (fire_cnt_ff >= FIRE_W'(MAX_RESULTS)) begin
                     // result budget used up: due channels stay armed at zero
                     rem_wd = due ? '0 : sub_time;
                  end else if (due) begin
                     rem_wd             = '0;
                     armed_in[e_idx_ff] = 1'b0;
                     fire_cnt_in        = fire_cnt_ff + FIRE_W'(1);
                     if (pend_valid_ff) begin
                        push                    = 1'b1;
                        push_data.fired         = 1'b1;
                        push_data.fired_channel = pend_ch_ff;
                        push_data.running       = active_ff;
                        push_data.last          = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_ch_in    = CHAN_W'(e_idx_ff);
                  end else begin
                     rem_wd = sub_time;
                  end
               end
               if (iss_ff < used_cnt) begin
                  rem_re     = 1'b1;
                  rem_ra     = iss_idx;
                  e_idx_in   = iss_idx;
                  e_valid_in = 1'b1;
                  iss_in     = iss_ff + CNT_W'(1);
               end else begin
                  e_valid_in = 1'b0;
                  state_in   = S_FLUSH;
               end
            end
         end

         // final beat: held firing, or a status beat
         S_FLUSH: begin
            if (out_free) begin
               push                    = 1'b1;
               push_data.fired         = pend_valid_ff;
               push_data.fired_channel = pend_valid_ff ? pend_ch_ff : '0;
               push_data.running       = active_ff;
               push_data.last          = 1'b1;
               pend_valid_in           = 1'b0;
               state_in                = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // output register
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         chain_mode_ff  <= 1'b0;
         chan_count_ff  <= COUNT_W'(1);
         armed_ff       <= '0;
         rem_written_ff <= '0;
         chain_pos_ff   <= '0;
         active_ff      <= 1'b0;
         paused_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         iss_ff         <= '0;
         e_valid_ff     <= 1'b0;
         fire_cnt_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         chain_mode_ff  <= chain_mode_in;
         chan_count_ff  <= chan_count_in;
         armed_ff       <= armed_in;
         rem_written_ff <= rem_written_in;
         chain_pos_ff   <= chain_pos_in;
         active_ff      <= active_in;
         paused_ff      <= paused_in;
         rsp_valid_ff   <= rsp_valid_in;
         pend_valid_ff  <= pend_valid_in;
         iss_ff         <= iss_in;
         e_valid_ff     <= e_valid_in;
         fire_cnt_ff    <= fire_cnt_in;
         rsp_data_ff    <= rsp_data_in;
         req_ff         <= req_in;
         pend_ch_ff     <= pend_ch_in;
         e_idx_ff       <= e_idx_in;
      end
   end

   // remaining-time memory, an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[rem_wa] <= rem_wd;
      end
      if (rem_re) begin
         rem_rd_ff     <= rem_mem[rem_ra];
         rd_written_ff <= rem_written_ff[rem_ra];
      end
   end

   // delay memory
   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_wa] <= dly_wd;
      end
      if (dly_re) begin
         dly_rd_ff <= dly_mem[dly_ra];
      end
   end

   `ASSERT_IMPLY(a_fire_running, clock, reset, rsp_valid_ff && rsp_data_ff.fired, rsp_data_ff.running)
   `ASSERT_IMPLY(a_scan_active, clock, reset, state_ff == S_SCAN, active_ff && !paused_ff)
   `ASSERT_IMPLY(a_scan_idx, clock, reset, (state_ff == S_SCAN) && e_valid_ff, CNT_W'(e_idx_ff) < used_cnt)
   `ASSERT_IMPLY(a_fire_budget, clock, reset, state_ff == S_SCAN, fire_cnt_ff <= FIRE_W'(MAX_RESULTS))
   `ASSERT_NEXT(a_chain_move, clock, reset, state_ff == S_CHAIN, pend_valid_ff == (chain_pos_ff != $past(chain_pos_ff)))

endmodule
